// ----- design/cfvp_pkg.sv -----
// ----------------------------------------------------------------------------
// cfvp_pkg: shared types and constants of the compact field varint parser
// Item structs, result and field kind codes, and the parse state layout.
// ----------------------------------------------------------------------------
package cfvp_pkg;

  localparam int VarintDigitW  = 7;   // data bits carried by one varint byte
  localparam int VarintMaxBytes = 5;  // longest legal varint for 32 bits
  localparam int ValueW        = 32;
  localparam int IdxW          = 3;

  typedef enum logic [2:0] {
    RES_DONE      = 3'd0,
    RES_PAYLOAD   = 3'd1,
    RES_NULL      = 3'd2,
    RES_MALFORMED = 3'd3,
    RES_ENDED     = 3'd4
  } result_kind_e;

  typedef enum logic [2:0] {
    FK_UNSIGNED = 3'd0,
    FK_SIGNED   = 3'd1,
    FK_STRING   = 3'd2,
    FK_ARRAY    = 3'd3,
    FK_TAGS     = 3'd4
  } field_kind_e;

  typedef enum logic [3:0] {
    PH_VARINT   = 4'b0001,
    PH_TAG_TYPE = 4'b0010,
    PH_TAG_LEN  = 4'b0100,
    PH_PAYLOAD  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [2:0] func;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    result_kind_e       result_kind;
    logic [ValueW-1:0]  value;
    logic signed [ValueW-1:0] signed_value;
    logic [7:0]         payload_byte;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic              busy;
    field_kind_e       kind;
    phase_e            phase;
    logic [ValueW-1:0] acc;
    logic [IdxW-1:0]   idx;
    logic [ValueW-1:0] tags;
    logic [ValueW-1:0] bytes;
  } parse_state_t;

  localparam parse_state_t IdleState = '{
    busy:  1'b0,
    kind:  FK_UNSIGNED,
    phase: PH_VARINT,
    acc:   '0,
    idx:   '0,
    tags:  '0,
    bytes: '0
  };

  // Zigzag decode: (raw >> 1) xor -(raw & 1).
  function automatic logic [ValueW-1:0] zigzag_decode(input logic [ValueW-1:0] raw);
    return {1'b0, raw[ValueW-1:1]} ^ {ValueW{raw[0]}};
  endfunction

endpackage

// ----- design/cfvp_step.sv -----
// ----------------------------------------------------------------------------
// cfvp_step: one-byte parse step
// Combinational next state and optional result for one message byte.
// ----------------------------------------------------------------------------
module cfvp_step import cfvp_pkg::*; (
  input  parse_state_t state_i,
  input  in_item_t     item_i,
  output parse_state_t state_o,
  output logic         res_valid_o,
  output out_item_t    res_o
);

  parse_state_t      cur;
  parse_state_t      nxt;
  logic [ValueW-1:0] digit;
  logic [ValueW-1:0] shifted;
  logic [ValueW-1:0] acc_new;
  logic [ValueW-1:0] len;
  logic [ValueW-1:0] tags_dec;
  logic [ValueW-1:0] bytes_dec;
  logic              cont;
  logic              complete;
  logic              malformed;
  logic              done;
  logic              tag_done;
  field_kind_e       start_kind;

  // Decode the field kind; unknown codes parse as unsigned.
  always_comb begin
    unique case (item_i.func)
      FK_SIGNED: start_kind = FK_SIGNED;
      FK_STRING: start_kind = FK_STRING;
      FK_ARRAY:  start_kind = FK_ARRAY;
      FK_TAGS:   start_kind = FK_TAGS;
      default:   start_kind = FK_UNSIGNED;
    endcase
  end

  always_comb begin
    cur = state_i;
    if (!cur.busy) begin
      cur.busy  = 1'b1;
      cur.kind  = start_kind;
      cur.phase = PH_VARINT;
      cur.acc   = '0;
      cur.idx   = '0;
    end

    // Place the 7 data bits at 7*idx; bits above 31 drop off.
    digit = {{(ValueW-VarintDigitW){1'b0}}, item_i.data_byte[VarintDigitW-1:0]};
    case (cur.idx)
      3'd0:    shifted = digit;
      3'd1:    shifted = digit << VarintDigitW;
      3'd2:    shifted = digit << (2*VarintDigitW);
      3'd3:    shifted = digit << (3*VarintDigitW);
      3'd4:    shifted = digit << (4*VarintDigitW);
      default: shifted = '0;
    endcase
    acc_new   = cur.acc | shifted;
    cont      = item_i.data_byte[VarintDigitW];
    len       = acc_new - ValueW'(1);
    tags_dec  = (cur.tags  != '0) ? cur.tags  - ValueW'(1) : '0;
    bytes_dec = (cur.bytes != '0) ? cur.bytes - ValueW'(1) : '0;

    nxt         = cur;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.result_kind = RES_DONE;
    complete    = 1'b0;
    malformed   = 1'b0;
    done        = 1'b0;
    tag_done    = 1'b0;

    if (cur.phase != PH_PAYLOAD) begin
      if (!cont) begin
        complete = 1'b1;
        nxt.acc  = '0;
        nxt.idx  = '0;
      end else begin
        nxt.acc = acc_new;
        nxt.idx = cur.idx + IdxW'(1);
        malformed = (cur.idx == IdxW'(VarintMaxBytes - 1));
      end
    end

    unique case (cur.phase)
      PH_VARINT: begin
        if (complete) begin
          res_valid_o = 1'b1;
          res_o.last  = 1'b1;
          case (cur.kind)
            FK_SIGNED: begin
              res_o.value        = acc_new;
              res_o.signed_value = zigzag_decode(acc_new);
              done = 1'b1;
            end
            FK_STRING: begin
              if (acc_new == '0) begin
                res_o.result_kind = RES_NULL;
                done = 1'b1;
              end else begin
                res_o.value = len;
                res_o.last  = (len == '0);
                if (len == '0) begin
                  done = 1'b1;
                end else begin
                  nxt.bytes = len;
                  nxt.phase = PH_PAYLOAD;
                end
              end
            end
            FK_ARRAY: begin
              res_o.value = (acc_new != '0) ? len : '0;
              done = 1'b1;
            end
            FK_TAGS: begin
              res_o.value = acc_new;
              res_o.last  = (acc_new == '0);
              if (acc_new == '0) begin
                done = 1'b1;
              end else begin
                nxt.tags  = acc_new;
                nxt.phase = PH_TAG_TYPE;
              end
            end
            default: begin
              res_o.value = acc_new;
              done = 1'b1;
            end
          endcase
        end
      end
      PH_TAG_TYPE: begin
        if (complete) begin
          nxt.phase = PH_TAG_LEN;
        end
      end
      PH_TAG_LEN: begin
        if (complete) begin
          if (acc_new == '0) begin
            tag_done = 1'b1;
          end else begin
            nxt.bytes = acc_new;
            nxt.phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        nxt.bytes = bytes_dec;
        if (cur.kind == FK_STRING) begin
          res_valid_o        = 1'b1;
          res_o.result_kind  = RES_PAYLOAD;
          res_o.payload_byte = item_i.data_byte;
          res_o.last         = (bytes_dec == '0);
          done               = (bytes_dec == '0);
        end else begin
          tag_done = (bytes_dec == '0);
        end
      end
      default: begin
        nxt = cur;
      end
    endcase

    // Close one skipped tag; the final one ends the field.
    if (tag_done) begin
      nxt.tags = tags_dec;
      if (tags_dec == '0) begin
        res_valid_o = 1'b1;
        res_o       = '0;
        res_o.result_kind = RES_DONE;
        res_o.last  = 1'b1;
        done        = 1'b1;
      end else begin
        nxt.phase = PH_TAG_TYPE;
      end
    end

    if (malformed) begin
      nxt         = IdleState;
      res_valid_o = 1'b1;
      res_o       = '0;
      res_o.result_kind = RES_MALFORMED;
      res_o.last  = 1'b1;
    end else if (done) begin
      nxt = IdleState;
    end else if (item_i.buffer_end) begin
      nxt         = IdleState;
      res_valid_o = 1'b1;
      res_o       = '0;
      res_o.result_kind = RES_ENDED;
      res_o.last  = 1'b1;
    end

    state_o = nxt;
  end

endmodule

// ----- design/compact_field_varint_parser_unit.sv -----
// ----------------------------------------------------------------------------
// compact_field_varint_parser_unit: byte-serial compact field parser
// Decodes base-128 varint fields, compact strings and tag buffers.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_ready_o / in_item_i) takes one message
//   byte per item together with the field kind (sampled on a field's first
//   byte) and a buffer-end flag. The output channel (out_valid_o /
//   out_ready_i / out_item_o) gives zero or one result item per input item:
//   a decoded value, a passed-through payload byte, a null marker or an
//   error, with last set on the final result of each field.
//   An accepted byte waits in the input register; its result, if any, is
//   registered in the result register that drives out_valid_o.
//   Throughput: one byte per cycle while the result register is free or
//   drains; the parse state feeds back through a single register stage,
//   so consecutive bytes of a field follow directly.
//   Stall: when the result register holds an item the receiver has not
//   taken, the input register holds its byte and in_ready_o drops only once
//   that register is also full; nothing is dropped.
//   Reset: rst_ni clears both valid flags and returns the parser to idle,
//   so the next byte starts a new field.
// ----------------------------------------------------------------------------
module compact_field_varint_parser_unit import cfvp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  // Input register
  logic         in_valid_q, in_valid_d;
  in_item_t     in_item_q;
  // Parse state
  parse_state_t state_q, state_d;
  // Result register
  logic         out_valid_q, out_valid_d;
  out_item_t    out_item_q;

  logic         step_adv;
  logic         res_valid;
  out_item_t    res_item;
  parse_state_t step_state;

  // Advance the held byte when the result register is free or drains now.
  assign step_adv   = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step_adv;

  cfvp_step u_step (
    .state_i     (state_q),
    .item_i      (in_item_q),
    .state_o     (step_state),
    .res_valid_o (res_valid),
    .res_o       (res_item)
  );

  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    state_d     = state_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (step_adv) begin
      in_valid_d = 1'b0;
    end
    if (step_adv) begin
      state_d     = step_state;
      out_valid_d = res_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= IdleState;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  // Payload registers: load on an input handshake or a step with a result, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
    if (step_adv && res_valid) begin
      out_item_q <= res_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ----- design/cfvp_checker.sv -----
// ----------------------------------------------------------------------------
// cfvp_checker: port-level checks of the compact field varint parser
// Observes the result channel and flags inconsistent result items.
// ----------------------------------------------------------------------------
module cfvp_checker import cfvp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // Hold a stalled result unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed or vanished");

  // Terminal kinds always close the field.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.result_kind == RES_NULL ||
                    out_item_o.result_kind == RES_MALFORMED ||
                    out_item_o.result_kind == RES_ENDED) |-> out_item_o.last)
    else $error("terminal result without last");

  // Only payload results carry a payload byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.result_kind != RES_PAYLOAD |->
      out_item_o.payload_byte == '0)
    else $error("payload byte on a non-payload result");

  // Only value results carry a value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.result_kind != RES_DONE |->
      out_item_o.value == '0 && out_item_o.signed_value == '0)
    else $error("value on a non-value result");

endmodule

bind compact_field_varint_parser_unit cfvp_checker u_cfvp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
